@@ hw/rtl/alc_pkg.sv @@
// ----------------------------------------------------------------------------
// alc_pkg
// Types, constants and the table builder shared by the lux calculator.
// ----------------------------------------------------------------------------
package alc_pkg;

  localparam int POW_TABLE_ENTRIES_DEF = 64;
  localparam int LUX_FRACTION_BITS_DEF = 16;
  localparam int CNT_W  = 16;
  localparam int LUX_W  = 27;
  localparam int POW_W  = 16;

  // Coefficients in Q32.
  localparam logic [31:0] K_B1_A = 32'd130567006;
  localparam logic [31:0] K_B1_B = 32'd266287972;
  localparam logic [31:0] K_B2_A = 32'd96207267;
  localparam logic [31:0] K_B2_B = 32'd133143986;
  localparam logic [31:0] K_B3_A = 32'd54975581;
  localparam logic [31:0] K_B3_B = 32'd65713000;
  localparam logic [31:0] K_B4_A = 32'd6270652;
  localparam logic [31:0] K_B4_B = 32'd4810363;

  typedef enum logic [2:0] {
    BAND_1    = 3'd0,
    BAND_2    = 3'd1,
    BAND_3    = 3'd2,
    BAND_4    = 3'd3,
    BAND_DARK = 3'd4,
    BAND_NONE = 3'd5
  } band_t;

  typedef struct packed {
    band_t            band;
    logic [CNT_W-1:0] c0;
    logic [CNT_W-1:0] c1;
  } item_t;

  // Table entry for x given in Q30: x^1.4 in Q16, via the fifth root of x^2.
  function automatic logic [POW_W-1:0] pow_entry(input longint unsigned x);
    longint unsigned sq, lo, hi, mid, t, e;
    sq = (x * x) >> 30;
    lo = 0;
    hi = 64'd1 << 30;
    while (lo < hi) begin
      mid = lo + ((hi - lo + 64'd1) >> 1);
      t = mid;
      for (int n = 0; n < 4; n++) begin
        t = (t * mid) >> 30;
      end
      if (t <= sq) begin
        lo = mid;
      end else begin
        hi = mid - 64'd1;
      end
    end
    e = (((x * lo) >> 30) + (64'd1 << 13)) >> 14;
    return e[POW_W-1:0];
  endfunction

endpackage

@@ hw/rtl/alc_front.sv @@
// ----------------------------------------------------------------------------
// alc_front
// Accepts a reading, sorts it into its formula band and hands it on.
// ----------------------------------------------------------------------------
module alc_front import alc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [CNT_W-1:0] in_ch0_count,
  input  logic [CNT_W-1:0] in_ch1_count,
  output logic             push,
  output item_t            push_item,
  input  logic             q_full
);

  logic  valid_r, valid_nxt;
  item_t item_r, item_nxt;
  logic [23:0] c1x100, c0x50, c0x61, c0x80, c0x130;
  band_t band;

  assign c1x100 = 24'(in_ch1_count) * 24'd100;
  assign c0x50  = 24'(in_ch0_count) * 24'd50;
  assign c0x61  = 24'(in_ch0_count) * 24'd61;
  assign c0x80  = 24'(in_ch0_count) * 24'd80;
  assign c0x130 = 24'(in_ch0_count) * 24'd130;

  always_comb begin
    if (in_ch0_count == '0) begin
      band = (in_ch1_count == '0) ? BAND_NONE : BAND_DARK;
    end else if (c1x100 <= c0x50) begin
      band = BAND_1;
    end else if (c1x100 <= c0x61) begin
      band = BAND_2;
    end else if (c1x100 <= c0x80) begin
      band = BAND_3;
    end else if (c1x100 <= c0x130) begin
      band = BAND_4;
    end else begin
      band = BAND_DARK;
    end
  end

  assign push      = valid_r && !q_full;
  assign push_item = item_r;
  assign busy      = valid_r && q_full;

  always_comb begin
    valid_nxt = valid_r && !push;
    item_nxt  = item_r;
    if (start && !busy) begin
      valid_nxt = 1'b1;
      item_nxt  = '{band: band, c0: in_ch0_count, c1: in_ch1_count};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

endmodule

@@ hw/rtl/alc_queue.sv @@
// ----------------------------------------------------------------------------
// alc_queue
// Two-entry queue between the classifying front and the arithmetic back.
// ----------------------------------------------------------------------------
module alc_queue import alc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  output logic  pop,
  output item_t pop_item
);

  item_t      mem [0:1];
  logic       wr_r, wr_nxt, rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  // The back end never stalls, so anything waiting leaves at once.
  assign pop      = (cnt_r != 2'd0);
  assign pop_item = mem[rd_r];

  always_comb begin
    wr_nxt  = wr_r ^ push;
    rd_nxt  = rd_r ^ pop;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      mem[wr_r] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("push into full queue");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 2'd1))
    else $error("queue count did not follow a lone push");

endmodule

@@ hw/rtl/alc_back.sv @@
// ----------------------------------------------------------------------------
// alc_back
// Ratio divider, r^1.4 interpolation and band formula, fully pipelined.
// ----------------------------------------------------------------------------
module alc_back import alc_pkg::*; #(
  parameter int POW_TABLE_ENTRIES = POW_TABLE_ENTRIES_DEF,
  parameter int LUX_FRACTION_BITS = LUX_FRACTION_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             pop,
  input  item_t            pop_item,
  output logic             out_valid,
  output logic [LUX_W-1:0] out_lux_value,
  output logic             out_no_reading
);

  localparam int N   = POW_TABLE_ENTRIES;
  localparam int IW  = $clog2(N + 1);
  localparam int PW  = CNT_W + IW;
  localparam int SH  = 32 - LUX_FRACTION_BITS;
  localparam int DW  = 48;
  localparam longint unsigned LUX_MAX = (64'd1 << LUX_W) - 64'd1;
  localparam longint unsigned NR_RAW  =
    ((64'd99999 << LUX_FRACTION_BITS) + 64'd50) / 64'd100;
  localparam logic [LUX_W-1:0] LUX_NOREAD =
    LUX_W'((NR_RAW > LUX_MAX) ? LUX_MAX : NR_RAW);

  // Constant r^1.4 table over [0, 0.5].
  logic [POW_W-1:0] rom [0:N];
  for (genvar k = 0; k <= N; k++) begin : g_rom
    localparam longint unsigned XK = (longint'(k) << 29) / N;
    localparam logic [POW_W-1:0] EK = pow_entry(XK);
    assign rom[k] = EK;
  end

  // Divider: one quotient bit per stage.
  logic             dv_v_r   [0:CNT_W];
  item_t            dv_it_r  [0:CNT_W];
  logic [CNT_W-1:0] dv_rem_r [0:CNT_W];
  logic [CNT_W-1:0] dv_q_r   [0:CNT_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else begin
      dv_v_r[0] <= pop;
    end
    dv_it_r[0]  <= pop_item;
    dv_rem_r[0] <= pop_item.c1;
    dv_q_r[0]   <= '0;
  end

  for (genvar j = 1; j <= CNT_W; j++) begin : g_div
    logic [CNT_W:0] t;
    logic           ge;
    assign t  = {dv_rem_r[j-1], 1'b0};
    assign ge = (t >= {1'b0, dv_it_r[j-1].c0});
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j] <= 1'b0;
      end else begin
        dv_v_r[j] <= dv_v_r[j-1];
      end
      dv_it_r[j]  <= dv_it_r[j-1];
      dv_rem_r[j] <= ge ? CNT_W'(t - {1'b0, dv_it_r[j-1].c0}) : t[CNT_W-1:0];
      dv_q_r[j]   <= {dv_q_r[j-1][CNT_W-2:0], ge};
    end
  end

  // Stage A: table position. Stage B: table read. Stage C: slope product.
  // Stage D: interpolated power. Stage E: first products. Stage F: band-1
  // product. Stage G: difference, rounding and saturation.
  logic  a_v_r, b_v_r, c_v_r, d_v_r, e_v_r, f_v_r;
  item_t a_it_r, b_it_r, c_it_r, d_it_r, e_it_r, f_it_r;
  logic [PW-1:0]      a_p_r;
  logic [IW-1:0]      a_i;
  logic [IW-1:0]      a_ib;
  logic               a_top;
  logic [POW_W-1:0]   b_a_r, b_b_r;
  logic [CNT_W-1:0]   b_f_r;
  logic               b_top_r;
  logic [POW_W-1:0]   c_a_r;
  logic [2*POW_W-1:0] c_prod_r;
  logic [POW_W-1:0]   d_pw_r;
  logic [CNT_W+POW_W-1:0] e_cp_r;
  logic [DW-1:0]      e_pos_r, e_nb_r, f_pos_r, f_neg_r;
  logic [31:0]        coef_a, coef_b;
  logic [63:0]        f_big;
  logic [DW-1:0]      g_d, g_r;
  logic [LUX_W-1:0]   g_lux;
  logic               lux_v_r;
  logic [LUX_W-1:0]   lux_r;
  logic               nr_r;

  assign a_i   = IW'(a_p_r[PW-1:CNT_W]);
  assign a_top = (a_i >= IW'(N));
  assign a_ib  = a_top ? IW'(N) : IW'(a_i + IW'(1));

  always_comb begin
    case (d_it_r.band)
      BAND_1:  begin coef_a = K_B1_A; coef_b = K_B1_B; end
      BAND_2:  begin coef_a = K_B2_A; coef_b = K_B2_B; end
      BAND_3:  begin coef_a = K_B3_A; coef_b = K_B3_B; end
      BAND_4:  begin coef_a = K_B4_A; coef_b = K_B4_B; end
      default: begin coef_a = '0;     coef_b = '0;     end
    endcase
  end

  assign f_big = 64'(K_B1_B) * 64'(e_cp_r);

  always_comb begin
    g_d   = f_pos_r - f_neg_r;
    g_r   = (g_d + (DW'(1) << (SH - 1))) >> SH;
    if (f_neg_r >= f_pos_r) begin
      g_lux = '0;
    end else if (g_r > DW'(LUX_MAX)) begin
      g_lux = LUX_W'(LUX_MAX);
    end else begin
      g_lux = g_r[LUX_W-1:0];
    end
    if (f_it_r.band == BAND_NONE) begin
      g_lux = LUX_NOREAD;
    end else if (f_it_r.band == BAND_DARK) begin
      g_lux = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r   <= 1'b0;
      b_v_r   <= 1'b0;
      c_v_r   <= 1'b0;
      d_v_r   <= 1'b0;
      e_v_r   <= 1'b0;
      f_v_r   <= 1'b0;
      lux_v_r <= 1'b0;
    end else begin
      a_v_r   <= dv_v_r[CNT_W];
      b_v_r   <= a_v_r;
      c_v_r   <= b_v_r;
      d_v_r   <= c_v_r;
      e_v_r   <= d_v_r;
      f_v_r   <= e_v_r;
      lux_v_r <= f_v_r;
    end
    a_it_r   <= dv_it_r[CNT_W];
    a_p_r    <= PW'(dv_q_r[CNT_W]) * PW'(2 * N);
    b_it_r   <= a_it_r;
    b_a_r    <= rom[a_i];
    b_b_r    <= rom[a_ib];
    b_f_r    <= a_p_r[CNT_W-1:0];
    b_top_r  <= a_top;
    c_it_r   <= b_it_r;
    c_a_r    <= b_top_r ? b_b_r : b_a_r;
    c_prod_r <= (b_top_r || (b_b_r < b_a_r)) ? '0 : (b_b_r - b_a_r) * b_f_r;
    d_it_r   <= c_it_r;
    d_pw_r   <= c_a_r + c_prod_r[2*POW_W-1:CNT_W];
    e_it_r   <= d_it_r;
    e_cp_r   <= (CNT_W+POW_W)'(d_it_r.c0) * (CNT_W+POW_W)'(d_pw_r);
    e_pos_r  <= DW'(coef_a) * DW'(d_it_r.c0);
    e_nb_r   <= DW'(coef_b) * DW'(d_it_r.c1);
    f_it_r   <= e_it_r;
    f_pos_r  <= e_pos_r;
    f_neg_r  <= (e_it_r.band == BAND_1) ? DW'(f_big >> 16) : e_nb_r;
    lux_r    <= g_lux;
    nr_r     <= (f_it_r.band == BAND_NONE);
  end

  assign out_valid      = lux_v_r;
  assign out_lux_value  = lux_r;
  assign out_no_reading = nr_r;

  a_noread_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_no_reading) |-> (out_lux_value == LUX_NOREAD))
    else $error("no-reading result without marker value");
  a_dark_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (f_v_r && f_it_r.band == BAND_DARK) |=> (out_valid && out_lux_value == '0))
    else $error("dark band result not zero");

endmodule

@@ hw/rtl/ambient_light_lux_calc.sv @@
// ----------------------------------------------------------------------------
// ambient_light_lux_calc
// Two-channel lux calculator: band selection, ratio, r^1.4 lookup, formula.
// ----------------------------------------------------------------------------
//  channel  | ports                                  | handshake
//  input    | in_ch0_count, in_ch1_count             | start && !busy
//  result   | out_lux_value, out_no_reading          | out_valid, one cycle
//
// One reading can be taken every clock cycle. Its result passes through one
// front register, the queue register, 17 divider stages (the first loads the
// operands, each later one yields a quotient bit) and arithmetic stages A to G.
// Reset (rst_n low, synchronous) empties every stage and the queue.
// The receiver cannot stall and the back end drains the queue every cycle,
// so the queue never fills and busy stays low.
// ----------------------------------------------------------------------------
module ambient_light_lux_calc import alc_pkg::*; #(
  parameter int POW_TABLE_ENTRIES = POW_TABLE_ENTRIES_DEF,
  parameter int LUX_FRACTION_BITS = LUX_FRACTION_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [CNT_W-1:0] in_ch0_count,
  input  logic [CNT_W-1:0] in_ch1_count,
  output logic             out_valid,
  output logic [LUX_W-1:0] out_lux_value,
  output logic             out_no_reading
);

  logic  push, q_full, pop;
  item_t push_item, pop_item;

  alc_front u_front (
    .clk, .rst_n, .start, .busy, .in_ch0_count, .in_ch1_count,
    .push, .push_item, .q_full
  );

  alc_queue u_queue (
    .clk, .rst_n, .push, .push_item, .full(q_full), .pop, .pop_item
  );

  alc_back #(
    .POW_TABLE_ENTRIES(POW_TABLE_ENTRIES),
    .LUX_FRACTION_BITS(LUX_FRACTION_BITS)
  ) u_back (
    .clk, .rst_n, .pop, .pop_item, .out_valid, .out_lux_value, .out_no_reading
  );

endmodule
